@@ sv/assert_macros.svh @@
// assertion macros shared by the multiply/divide unit rtl
// needs clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define MDU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition now implies consequence in the next cycle
`define MDU_ASSERT_NEXT(label, cond, cons, msg) \
  `MDU_ASSERT(label, (cond) |=> (cons), msg)

`endif

@@ sv/mdu_pkg.sv @@
// shared constants and types for the 128-bit multiply/divide unit
// no dependencies
package mdu_pkg;

  localparam int unsigned HalfW  = 64;
  localparam int unsigned WordW  = 2 * HalfW;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned InDataW  = 4 * HalfW;
  localparam int unsigned OutDataW = 2 * HalfW;

  // operation codes carried in the input tuser
  localparam logic [ModeW-1:0] MODE_MUL  = 3'd0;
  localparam logic [ModeW-1:0] MODE_DIVS = 3'd1;
  localparam logic [ModeW-1:0] MODE_DIVU = 3'd2;
  localparam logic [ModeW-1:0] MODE_REMS = 3'd3;
  localparam logic [ModeW-1:0] MODE_REMU = 3'd4;

  // one operation in flight through the cell row
  typedef struct packed {
    logic             valid;
    logic             is_mul;
    logic             want_quot;
    logic             neg_q;
    logic             neg_r;
    logic             dz;
    logic             kill;
    logic [WordW-1:0] rr;   // partial remainder or product accumulator
    logic [WordW-1:0] n;    // dividend / multiplier bits out, quotient bits in
    logic [WordW-1:0] d;    // divisor or multiplicand
  } mdu_lane_t;

endpackage

@@ sv/int128_multiply_divide_unit.sv @@
// top level of the 128-bit multiply/divide unit: operand prep, cell row, result stage
// depends on mdu_pkg, mdu_cell and assert_macros.svh
//
// usage:
//   slave channel takes one operation per transfer: tuser carries the mode
//   (0 multiply, 1 signed quotient, 2 unsigned quotient, 3 signed remainder,
//   4 unsigned remainder), tdata the operands a and b as 64-bit halves
//   master channel returns one result per operation, in order: tdata is the
//   128-bit result, tuser is the divide-by-zero flag
//   from the input transfer to the output valid an operation passes through
//   one operand register, 128 step cells (one bit of b or of the dividend
//   each) and one result register
//   throughput is one operation per cycle; the whole row moves in lockstep
//   when the result register is empty or being taken
//   when the receiver stalls with a result waiting, the row holds and
//   s_axis_tready drops until the result is taken
//   reset clears every valid bit; no result is pending after reset
module int128_multiply_divide_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // a_low, a_high, b_low, b_high
  input  logic [mdu_pkg::InDataW-1:0]  s_axis_tdata,
  // mode
  input  logic [mdu_pkg::ModeW-1:0]    s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // result_low, result_high
  output logic [mdu_pkg::OutDataW-1:0] m_axis_tdata,
  // divide_by_zero
  output logic                         m_axis_tuser
);
  import mdu_pkg::*;

  `include "assert_macros.svh"

  // row advances when the result slot is free or draining
  logic advance;

  logic [WordW-1:0] op_a, op_b, mag_a, mag_b;
  logic [ModeW-1:0] mode;
  logic             is_div, is_signed, b_zero, neg_a, neg_b;
  mdu_lane_t        prep_d, prep_q;
  logic             prep_valid_q;
  mdu_lane_t        lane [0:WordW];

  logic [WordW-1:0] res_d, res_q;
  logic             dz_d, dz_q, out_valid_q;
  mdu_lane_t        last;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;

  // operand prep: signs stripped, zero divisor left unsigned so the row
  // itself yields all-ones quotient and the dividend as remainder
  always_comb begin
    mode      = s_axis_tuser;
    op_a      = s_axis_tdata[WordW-1:0];
    op_b      = s_axis_tdata[InDataW-1:WordW];
    is_div    = (mode == MODE_DIVS) || (mode == MODE_DIVU) ||
                (mode == MODE_REMS) || (mode == MODE_REMU);
    is_signed = (mode == MODE_DIVS) || (mode == MODE_REMS);
    b_zero    = (op_b == '0);
    neg_a     = is_signed && !b_zero && op_a[WordW-1];
    neg_b     = is_signed && !b_zero && op_b[WordW-1];
    mag_a     = neg_a ? (~op_a + 1'b1) : op_a;
    mag_b     = neg_b ? (~op_b + 1'b1) : op_b;

    prep_d           = '0;
    prep_d.valid     = s_axis_tvalid;
    prep_d.is_mul    = (mode == MODE_MUL);
    prep_d.want_quot = (mode == MODE_DIVS) || (mode == MODE_DIVU);
    prep_d.neg_q     = neg_a ^ neg_b;
    prep_d.neg_r     = neg_a;
    prep_d.dz        = is_div && b_zero;
    prep_d.kill      = !is_div && (mode != MODE_MUL);
    prep_d.rr        = '0;
    // multiply feeds b bits msb first against multiplicand a
    prep_d.n         = (mode == MODE_MUL) ? op_b : mag_a;
    prep_d.d         = (mode == MODE_MUL) ? op_a : mag_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (advance) begin
      prep_valid_q <= prep_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      prep_q <= prep_d;
    end
  end

  always_comb begin
    lane[0]       = prep_q;
    lane[0].valid = prep_valid_q;
  end

  // one cell per operand bit
  for (genvar i = 0; i < WordW; i++) begin : g_cell
    mdu_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .lane_i (lane[i]),
      .lane_o (lane[i+1])
    );
  end

  // result select (zero for an unused mode) and sign fix-up
  always_comb begin
    last = lane[WordW];
    if (last.kill) begin
      res_d = '0;
    end else if (last.is_mul) begin
      res_d = last.rr;
    end else if (last.want_quot) begin
      res_d = last.neg_q ? (~last.n + 1'b1) : last.n;
    end else begin
      res_d = last.neg_r ? (~last.rr + 1'b1) : last.rr;
    end
    dz_d = last.dz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
      dz_q  <= dz_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = dz_q;

  // a stalled result stays put
  `MDU_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
                   "result dropped while stalled")
  `MDU_ASSERT_NEXT(a_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata),
                   "result changed while stalled")
  // a stalled row moves nothing forward
  `MDU_ASSERT_NEXT(a_row_hold, !advance, $stable(lane[WordW].valid),
                   "cell row moved while stalled")
  // flag only for divide modes
  `MDU_ASSERT(a_dz_kind, last.valid && last.dz |-> !last.is_mul && !last.kill,
              "divide-by-zero flag on a non-divide operation")

endmodule

@@ sv/mdu_cell.sv @@
// one step cell: a restoring divide step or a shift-add multiply step
// depends on mdu_pkg
module mdu_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  mdu_pkg::mdu_lane_t lane_i,
  output mdu_pkg::mdu_lane_t lane_o
);
  import mdu_pkg::*;

  logic             valid_q;
  mdu_lane_t        lane_d, lane_q;
  logic [WordW-1:0] shifted;
  logic [WordW:0]   diff;
  logic [WordW-1:0] sum;
  logic             take;

  always_comb begin
    shifted = {lane_i.rr[WordW-2:0], lane_i.n[WordW-1]};
    diff    = {lane_i.rr[WordW-1], shifted} - {1'b0, lane_i.d};
    sum     = {lane_i.rr[WordW-2:0], 1'b0} + (lane_i.n[WordW-1] ? lane_i.d : '0);
    take    = !diff[WordW];
    lane_d  = lane_i;
    if (lane_i.is_mul) begin
      lane_d.rr = sum;
      lane_d.n  = {lane_i.n[WordW-2:0], 1'b0};
    end else begin
      lane_d.rr = take ? diff[WordW-1:0] : shifted;
      lane_d.n  = {lane_i.n[WordW-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= lane_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  always_comb begin
    lane_o       = lane_q;
    lane_o.valid = valid_q;
  end

endmodule

@@ tb/int128_multiply_divide_unit_test.sv @@
// testbench for the 128-bit multiply/divide unit: directed and random operations,
// checked against a behavioral predictor; depends on mdu_pkg and the unit rtl
module int128_multiply_divide_unit_test;
  import mdu_pkg::*;

  typedef struct {
    logic [63:0] res_lo;
    logic [63:0] res_hi;
    logic        dz;
  } mdu_result_t;

  int unsigned mismatch_count = 0;

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [127:0] got,
                                 input logic [127:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatch_count++;
  endtask

  // behavioral model of one operation
  function automatic mdu_result_t compute_result(input logic [2:0] mode,
                                                 input logic [127:0] a,
                                                 input logic [127:0] b);
    mdu_result_t r;
    logic [127:0] ma, mb, q, rm, res;
    logic na, nb, sgn, quot;
    res = '0;
    r.dz = 1'b0;
    if (mode == MODE_MUL) begin
      res = a * b;
    end else if (mode <= MODE_REMU) begin
      sgn  = (mode == MODE_DIVS) || (mode == MODE_REMS);
      quot = (mode == MODE_DIVS) || (mode == MODE_DIVU);
      if (b == '0) begin
        r.dz = 1'b1;
        res = quot ? {128{1'b1}} : a;
      end else begin
        na = sgn && a[127];
        nb = sgn && b[127];
        ma = na ? -a : a;
        mb = nb ? -b : b;
        q  = ma / mb;
        rm = ma % mb;
        if (quot) res = (na != nb) ? -q : q;
        else res = na ? -rm : rm;
      end
    end
    r.res_lo = res[63:0];
    r.res_hi = res[127:64];
    return r;
  endfunction

  class mdu_scoreboard;
    mdu_result_t pending_results[$];

    function void note_operation(logic [2:0] mode, logic [127:0] a, logic [127:0] b);
      pending_results.push_back(compute_result(mode, a, b));
    endfunction

    task check_result(logic [127:0] data, logic dz);
      mdu_result_t w;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", data, '0);
      end else begin
        w = pending_results.pop_front();
        if (data[63:0] !== w.res_lo) report_mismatch("result_low", data[63:0], w.res_lo);
        if (data[127:64] !== w.res_hi) report_mismatch("result_high", data[127:64], w.res_hi);
        if (dz !== w.dz) report_mismatch("divide_by_zero", dz, w.dz);
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [ModeW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tuser;

  mdu_scoreboard scoreboard = new();
  bit stimulus_done = 1'b0;
  bit long_hold = 1'b0;

  int128_multiply_divide_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),   // a_low, a_high, b_low, b_high
    .s_axis_tuser(s_axis_tuser),   // mode
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),   // result_low, result_high
    .m_axis_tuser(m_axis_tuser)    // divide_by_zero
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned gap_length();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  function automatic logic [127:0] rand_word();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // operand shapes that reach the interesting corners
  function automatic logic [127:0] rand_operand();
    logic [127:0] w;
    case ($urandom_range(7))
      0: w = rand_word();
      1: w = rand_word() >> $urandom_range(127);
      2: w = -(rand_word() >> $urandom_range(127));
      3: w = {64'd0, $urandom(), $urandom()};
      4: w = 128'(1) << $urandom_range(127);
      5: w = {1'b1, 127'd0};
      6: w = $urandom_range(3) == 0 ? 128'd0 : {128{1'b1}};
      default: w = 128'($urandom_range(20));
    endcase
    return w;
  endfunction

  // offer one operation and hold it until the transfer happens
  task automatic send_operation(input logic [2:0] mode, input logic [127:0] a,
                                input logic [127:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    scoreboard.note_operation(mode, a, b);
  endtask

  task automatic send_with_gap(input logic [2:0] mode, input logic [127:0] a,
                               input logic [127:0] b);
    int unsigned g;
    send_operation(mode, a, b);
    g = (long_hold) ? 0 : gap_length();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // receiver: random stalls plus one long hold-off so the row fills and stalls the input
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        scoreboard.check_result(m_axis_tdata, m_axis_tuser);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
      end else begin
        g = $urandom_range(99);
        m_axis_tready <= (g < 70) || (g >= 97 ? 1'b0 : $urandom_range(1));
      end
    end
  end

  initial begin
    logic [127:0] min_v, neg1;
    logic [2:0] m;
    int unsigned wait_cycles;
    min_v = {1'b1, 127'd0};
    neg1  = {128{1'b1}};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every mode with extremes, zero divisor, minimum over minus one
    for (int k = 0; k <= 4; k++) begin
      m = 3'(k);
      send_with_gap(m, neg1, neg1);
      send_with_gap(m, min_v, neg1);
      send_with_gap(m, rand_word(), 128'd0);
      send_with_gap(m, 128'd0, 128'd7);
    end
    send_with_gap(MODE_DIVS, -128'sd7, 128'd2);
    send_with_gap(MODE_REMS, -128'sd7, 128'd2);
    send_with_gap(3'd5, neg1, neg1);
    send_with_gap(3'd6, neg1, neg1);
    send_with_gap(3'd7, neg1, 128'd0);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        long_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      begin
        for (int k = 0; k < 200; k++)
          send_with_gap(3'($urandom_range(4)), rand_operand(), rand_operand());
      end
    join

    for (int k = 0; k < 2000; k++) begin
      m = ($urandom_range(49) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_with_gap(m, rand_operand(), rand_operand());
    end
    s_axis_tvalid <= 1'b0;

    wait_cycles = 0;
    while (scoreboard.pending_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && scoreboard.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+sv
sv/mdu_pkg.sv
sv/mdu_cell.sv
sv/int128_multiply_divide_unit.sv
tb/int128_multiply_divide_unit_test.sv
